// ----- sv/dtw_pkg.sv -----
`default_nettype none
package dtw_pkg;

	localparam int HIT_CAPACITY = 64;
	localparam int TIME_W       = 20;
	localparam int TAG_W        = 32;

	localparam int CNT_W     = $clog2(HIT_CAPACITY + 1);
	localparam int IDX_W     = (HIT_CAPACITY > 1) ? $clog2(HIT_CAPACITY) : 1;
	localparam int NUM_BANKS = 2;
	localparam int BANK_W    = 1;
	localparam int ADDR_W    = IDX_W + BANK_W;
	localparam int MEM_DEPTH = NUM_BANKS << IDX_W;

	// window bounds grow past the time width before truncation
	localparam int LO_W      = TIME_W + 1;
	localparam int HI_W      = TIME_W + 2;
	localparam int MOD_CNT_W = $clog2(TIME_W + 1);

	localparam int IN_DATA_W  = ((TIME_W + TAG_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * TIME_W + TAG_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_STEP   = 1'b1;

	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 20'd160;
	localparam logic [TIME_W-1:0] WINDOW_STEP_RST   = 20'd16;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] hit_time;
		logic [TAG_W-1:0]  hit_tag;
	} hit_wr_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0]  count;
		logic              ovf;
	} evt_desc_t;

	typedef struct packed {
		logic      valid;
		evt_desc_t desc;
	} evt_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_BEST,
		ST_CAND_RD,
		ST_CAND_WAIT,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_CHK,
		ST_EMIT_NONE,
		ST_DONE
	} search_state_t;

endpackage
`default_nettype wire

// ----- sv/dtw_loader.sv -----
`default_nettype none
module dtw_loader (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [dtw_pkg::IN_DATA_W-1:0] s_tdata, // hit_time, hit_tag, zero pad
	input  wire logic                         s_tlast,  // last_hit
	input  wire logic                         q_full,
	output logic                              q_push,
	output dtw_pkg::evt_desc_t                q_push_desc,
	output dtw_pkg::hit_wr_t                  hit_wr
);
	import dtw_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [BANK_W-1:0] bank_q;
	logic              accept;
	logic              room;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              ovf_nxt;

	// a bank is free while the queue holds fewer events than there are banks
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign room     = cnt_q < CNT_W'(HIT_CAPACITY);
	assign cnt_nxt  = room ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign ovf_nxt  = ovf_q || !room;

	assign hit_wr.en       = accept && room;
	assign hit_wr.addr     = {bank_q, cnt_q[IDX_W-1:0]};
	assign hit_wr.hit_time = s_tdata[TIME_W-1:0];
	assign hit_wr.hit_tag  = s_tdata[TIME_W +: TAG_W];

	assign q_push            = accept && s_tlast;
	assign q_push_desc.bank  = bank_q;
	assign q_push_desc.count = cnt_nxt;
	assign q_push_desc.ovf   = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			bank_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				bank_q <= bank_q + 1'b1;
			end else begin
				cnt_q <= cnt_nxt;
				ovf_q <= ovf_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/dtw_evt_fifo.sv -----
`default_nettype none
module dtw_evt_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  dtw_pkg::evt_desc_t push_desc,
	input  wire logic          pop,
	output logic               full,
	output dtw_pkg::evt_head_t head
);
	import dtw_pkg::*;

	evt_desc_t         mem_q [NUM_BANKS];
	logic [BANK_W-1:0] wr_ptr_q;
	logic [BANK_W-1:0] rd_ptr_q;
	logic [BANK_W:0]   fill_q;

	assign full       = fill_q == (BANK_W+1)'(NUM_BANKS);
	assign head.valid = fill_q != '0;
	assign head.desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/dtw_mod.sv -----
`default_nettype none
module dtw_mod (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [dtw_pkg::TIME_W-1:0] dividend,
	input  wire logic [dtw_pkg::TIME_W-1:0] divisor,
	output logic                           done,
	output logic [dtw_pkg::TIME_W-1:0]     rem
);
	import dtw_pkg::*;

	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dvd_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_W:0]      trial;
	logic [TIME_W:0]      trial_sub;
	logic                 ge;

	// restoring remainder, one dividend bit per cycle
	assign trial     = {rem_q, dvd_q[TIME_W-1]};
	assign ge        = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};

	assign done = done_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MOD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

// ----- sv/dtw_search.sv -----
`default_nettype none
module dtw_search (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [dtw_pkg::TIME_W-1:0]     window_length,
	input  wire logic [dtw_pkg::TIME_W-1:0]     window_step,
	input  dtw_pkg::hit_wr_t                    hit_wr,
	input  dtw_pkg::evt_head_t                  head,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dtw_pkg::OUT_DATA_W-1:0]      m_tdata, // out_time, out_tag, window_start
	output logic [dtw_pkg::OUT_USER_W-1:0]      m_tuser, // none_selected, overflowed
	output logic                                m_tlast  // last_result
);
	import dtw_pkg::*;

	logic [TIME_W-1:0] time_mem [MEM_DEPTH];
	logic [TAG_W-1:0]  tag_mem  [MEM_DEPTH];

	search_state_t state_q, state_d;

	evt_desc_t         desc_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  best_n_q;
	logic [CNT_W-1:0]  emit_n_q;
	logic [LO_W-1:0]   lo_q;
	logic [HI_W-1:0]   hi_q;
	logic [LO_W-1:0]   best_lo_q;
	logic              base_q;
	logic              pend_s1;
	logic [TIME_W-1:0] rd_time_q;
	logic [TAG_W-1:0]  rd_tag_q;

	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [TIME_W-1:0] out_start_q;
	logic              out_none_q;
	logic              out_ovf_q;
	logic              out_last_q;

	logic              rd_en;
	logic [CNT_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic              mod_start;
	logic              mod_done;
	logic [TIME_W-1:0] mod_rem;
	logic              out_load;
	logic              out_free;
	logic [TIME_W-1:0] step_eff;
	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] lo_adj;
	logic [LO_W-1:0]   lo_new;
	logic [HI_W-1:0]   hi_new;
	logic [HI_W-1:0]   best_hi;
	logic              in_win;
	logic              better;
	logic              last_emit;
	logic              cand_end;

	dtw_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (diff),
		.divisor  (step_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign rd_addr  = {desc_q.bank, rd_idx[IDX_W-1:0]};
	assign step_eff = (window_step == '0) ? TIME_W'(1) : window_step;
	assign diff     = rd_time_q - window_length;
	// window start: (t - len) rounded up to a multiple of the step
	assign lo_adj   = (mod_rem == '0) ? '0 : step_eff - mod_rem;
	assign lo_new   = {1'b0, diff} + {1'b0, lo_adj};
	assign hi_new   = {1'b0, lo_new} + {2'b00, window_length};
	assign best_hi  = {1'b0, best_lo_q} + {2'b00, window_length};
	assign in_win   = ({2'b00, rd_time_q} >= {1'b0, lo_q}) && ({2'b00, rd_time_q} <= hi_q);
	assign better   = base_q || (cnt_q > best_n_q) ||
	                  ((cnt_q == best_n_q) && (cnt_q != '0) && (lo_q < best_lo_q));
	assign out_free  = !out_valid_q || m_tready;
	assign last_emit = CNT_W'(emit_n_q + 1'b1) == best_n_q;
	assign cand_end  = i_q == desc_q.count;

	always_ff @(posedge clk) begin
		if (hit_wr.en) begin
			time_mem[hit_wr.addr] <= hit_wr.hit_time;
			tag_mem[hit_wr.addr]  <= hit_wr.hit_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_time_q <= time_mem[rd_addr];
			rd_tag_q  <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_idx    = j_q;
		pop       = 1'b0;
		mod_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid)
					state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (j_q != desc_q.count)
					rd_en = 1'b1;
				else if (!pend_s1)
					state_d = ST_BEST;
			end
			ST_BEST: state_d = ST_CAND_RD;
			ST_CAND_RD: begin
				if (cand_end) begin
					state_d = (best_n_q == '0) ? ST_EMIT_NONE : ST_EMIT_RD;
				end else begin
					rd_en   = 1'b1;
					rd_idx  = i_q;
					state_d = ST_CAND_WAIT;
				end
			end
			ST_CAND_WAIT: begin
				if (rd_time_q <= window_length) begin
					state_d = ST_CAND_RD;
				end else begin
					mod_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (mod_done)
					state_d = ST_COUNT;
			end
			ST_EMIT_RD: begin
				if (j_q == desc_q.count) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_EMIT_CHK;
				end
			end
			ST_EMIT_CHK: begin
				if (!in_win) begin
					state_d = ST_EMIT_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_EMIT_RD;
				end
			end
			ST_EMIT_NONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				pop     = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q    <= '0;
			j_q       <= '0;
			i_q       <= '0;
			cnt_q     <= '0;
			best_n_q  <= '0;
			emit_n_q  <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			best_lo_q <= '0;
			base_q    <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_COUNT) && rd_en;
			unique case (state_q)
				ST_IDLE: begin
					desc_q <= head.desc;
					lo_q   <= '0;
					hi_q   <= {2'b00, window_length};
					j_q    <= '0;
					cnt_q  <= '0;
					base_q <= 1'b1;
				end
				ST_COUNT: begin
					if (rd_en)
						j_q <= j_q + 1'b1;
					if (pend_s1 && in_win)
						cnt_q <= cnt_q + 1'b1;
				end
				ST_BEST: begin
					if (better) begin
						best_n_q  <= cnt_q;
						best_lo_q <= lo_q;
					end
					i_q    <= base_q ? '0 : CNT_W'(i_q + 1'b1);
					base_q <= 1'b0;
				end
				ST_CAND_RD: begin
					if (cand_end) begin
						j_q      <= '0;
						emit_n_q <= '0;
						lo_q     <= best_lo_q;
						hi_q     <= best_hi;
					end
				end
				ST_CAND_WAIT: begin
					if (rd_time_q <= window_length)
						i_q <= i_q + 1'b1;
				end
				ST_DIV: begin
					if (mod_done) begin
						lo_q  <= lo_new;
						hi_q  <= hi_new;
						j_q   <= '0;
						cnt_q <= '0;
					end
				end
				ST_EMIT_RD: begin
					if (rd_en)
						j_q <= j_q + 1'b1;
				end
				ST_EMIT_CHK: begin
					if (out_load)
						emit_n_q <= emit_n_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ovf_q <= desc_q.ovf;
			if (state_q == ST_EMIT_NONE) begin
				out_time_q  <= '0;
				out_tag_q   <= '0;
				out_start_q <= '0;
				out_none_q  <= 1'b1;
				out_last_q  <= 1'b1;
			end else begin
				out_time_q  <= rd_time_q;
				out_tag_q   <= rd_tag_q;
				out_start_q <= lo_q[TIME_W-1:0];
				out_none_q  <= 1'b0;
				out_last_q  <= last_emit;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_start_q, out_tag_q, out_time_q});
	assign m_tuser  = {out_ovf_q, out_none_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- sv/densest_time_window_hit_filter_unit.sv -----
// Densest time window hit filter.
// Slave stream: one hit per transfer, tdata = {pad, hit_tag, hit_time}, tlast on the
// last hit of an event. Hits are taken one per cycle into one of two hit banks; a
// third event waits (s_tready low) until the search has finished with a bank.
// Hits past 64 in an event are dropped and flagged in the results of that event.
// After the last hit, the search block scores window 0 and, for each stored hit past
// the window length, the first window that reaches it. Each score is a pass over the
// n stored hits and a compare state; each later window also needs a read state, a
// wait state and a pass through the remainder unit. Emission reads every stored hit
// in turn and checks it against the best window.
// Master stream: tdata = {window_start, out_tag, out_time}, tuser = {overflowed,
// none_selected}, tlast on the final result of the event. An empty window gives a
// single transfer with none_selected set and zero data.
// The output is a register: a stalled receiver holds the search, not the loading of
// the next event. Reset empties both banks and the queue and sets window_length to
// 160 and window_step to 16. Configuration writes are registered.
`default_nettype none
module densest_time_window_hit_filter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [dtw_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [dtw_pkg::TIME_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dtw_pkg::IN_DATA_W-1:0]  s_tdata, // hit_time, hit_tag, zero pad
	input  wire logic                           s_tlast, // last_hit
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dtw_pkg::OUT_DATA_W-1:0]      m_tdata, // out_time, out_tag, window_start
	output logic [dtw_pkg::OUT_USER_W-1:0]      m_tuser, // none_selected, overflowed
	output logic                                m_tlast  // last_result
);
	import dtw_pkg::*;

	logic [TIME_W-1:0] window_length_q;
	logic [TIME_W-1:0] window_step_q;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	evt_desc_t         q_push_desc;
	evt_head_t         q_head;
	hit_wr_t           hit_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			window_step_q   <= WINDOW_STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				REG_WINDOW_STEP:   window_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	dtw_loader u_loader (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_push_desc (q_push_desc),
		.hit_wr      (hit_wr)
	);

	dtw_evt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_push_desc),
		.pop       (q_pop),
		.full      (q_full),
		.head      (q_head)
	);

	dtw_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_length (window_length_q),
		.window_step   (window_step_q),
		.hit_wr        (hit_wr),
		.head          (q_head),
		.pop           (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

`ifndef ASSERT_OFF
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
		else $error("empty-window result not final or not zero");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("event queued with both banks held");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("search released a bank it did not hold");
`endif

endmodule
`default_nettype wire
